/* src/cpfv_pkg.sv */
`default_nettype none

package cpfv_pkg;

    localparam int DIGIT_COUNT = 11;
    localparam int DIGIT_W     = 4;
    localparam int COUNT_W     = 4;
    localparam int SUM_W       = 10;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [7:0] ASCII_ZERO = 8'd48;
    localparam logic [7:0] ASCII_NINE = 8'd57;
    localparam logic [3:0] CHECK_BASE = 4'd10;
    localparam logic [3:0] MODULUS    = 4'd11;

    localparam logic [COUNT_W-1:0] COUNT_MAX = COUNT_W'(DIGIT_COUNT);

    // floor(s / 11) is q or q + 1 with q = (s * 372) >> 12, for s below 1024
    localparam logic [8:0] RECIP_11   = 9'd372;
    localparam int         RECIP_SHIFT = 12;

    localparam logic [DIGIT_W-1:0] WEIGHT_FIRST [DIGIT_COUNT] =
        '{4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd0, 4'd0};
    localparam logic [DIGIT_W-1:0] WEIGHT_SECOND [DIGIT_COUNT] =
        '{4'd11, 4'd10, 4'd9, 4'd8, 4'd7, 4'd6, 4'd5, 4'd4, 4'd3, 4'd2, 4'd0};

    typedef enum logic [2:0] {
        ST_OK     = 3'd0,
        ST_EMPTY  = 3'd1,
        ST_LENGTH = 3'd2,
        ST_EQUAL  = 3'd3,
        ST_FIRST  = 3'd4,
        ST_SECOND = 3'd5
    } status_t;

    typedef logic [DIGIT_COUNT-1:0][DIGIT_W-1:0] window_t;

    typedef struct packed {
        logic               is_digit;
        logic [DIGIT_W-1:0] digit;
        logic               last;
        logic               empty;
    } token_t;

    typedef struct packed {
        logic    empty;
        logic    too_many;
        window_t window;
    } job_t;

endpackage

`default_nettype wire

/* src/cpfv_front.sv */
`default_nettype none

module cpfv_front (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            s_valid,
    output logic                 s_ready,
    input  wire logic [7:0]      s_char_byte,
    input  wire logic            s_last_char,
    input  wire logic            s_empty_string,
    input  wire logic            q_full,
    output logic                 q_push,
    output cpfv_pkg::token_t     q_token
);
    import cpfv_pkg::*;

    logic is_digit;
    logic keep;
    logic [7:0] offset;

    assign offset   = s_char_byte - ASCII_ZERO;
    assign is_digit = (s_char_byte >= ASCII_ZERO) && (s_char_byte <= ASCII_NINE);

    // drop empty flags without last, and non-digits that do not close a string
    assign keep = s_empty_string ? s_last_char : (is_digit || s_last_char);

    assign s_ready = !q_full;
    assign q_push  = s_valid && !q_full && keep;

    always_comb begin
        q_token.empty    = s_empty_string;
        q_token.last     = s_last_char;
        q_token.is_digit = is_digit && !s_empty_string;
        q_token.digit    = is_digit ? offset[DIGIT_W-1:0] : '0;
    end

`ifndef SYNTH
    a_push_kept: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> (s_last_char || q_token.is_digit))
        else $error("front pushed a token with no effect");
    a_push_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        q_push |-> s_ready)
        else $error("front pushed without accepting a beat");
    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_push && q_token.empty) |-> (q_token.last && !q_token.is_digit))
        else $error("empty token without last");
`endif

endmodule

`default_nettype wire

/* src/cpfv_queue.sv */
`default_nettype none

module cpfv_queue #(
    parameter int DEPTH = cpfv_pkg::QUEUE_DEPTH
) (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            push,
    input  cpfv_pkg::token_t     push_data,
    output logic                 full,
    input  wire logic            pop,
    output cpfv_pkg::token_t     pop_data,
    output logic                 nonempty
);
    import cpfv_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    token_t            slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign full     = (count_reg == CNT_W'(DEPTH));
    assign nonempty = (count_reg != '0);
    assign pop_data = slot_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, pop})
            2'b10:   count_next = count_reg + 1'b1;
            2'b01:   count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_data;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> !full)
        else $error("push into full queue");
    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> nonempty)
        else $error("pop from empty queue");
    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

`default_nettype wire

/* src/cpfv_track.sv */
`default_nettype none

module cpfv_track (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  cpfv_pkg::token_t     q_token,
    input  wire logic            q_nonempty,
    output logic                 q_pop,
    output logic                 job_valid,
    input  wire logic            job_ready,
    output cpfv_pkg::job_t       job
);
    import cpfv_pkg::*;

    window_t             window_reg, window_next;
    logic [COUNT_W-1:0]  count_reg, count_next;
    window_t             window_upd;
    logic [COUNT_W-1:0]  count_upd;

    assign job_valid = q_nonempty && q_token.last;
    assign q_pop     = q_nonempty && (!q_token.last || job_ready);

    always_comb begin
        window_upd = window_reg;
        count_upd  = count_reg;
        if (q_token.is_digit) begin
            window_upd[DIGIT_COUNT-2:0]   = window_reg[DIGIT_COUNT-1:1];
            window_upd[DIGIT_COUNT-1]     = q_token.digit;
            if (count_reg <= COUNT_MAX) begin
                count_upd = count_reg + 1'b1;
            end
        end

        job.empty    = q_token.empty;
        job.too_many = (count_upd > COUNT_MAX);
        job.window   = window_upd;

        window_next = window_reg;
        count_next  = count_reg;
        if (q_pop) begin
            if (q_token.last) begin
                window_next = '0;
                count_next  = '0;
            end else begin
                window_next = window_upd;
                count_next  = count_upd;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg <= '0;
            count_reg  <= '0;
        end else begin
            window_reg <= window_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_count_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_MAX + 1'b1)
        else $error("digit count past saturation");
    a_clear_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (q_pop && q_token.last) |=> (count_reg == '0 && window_reg == '0))
        else $error("state not cleared after last beat");
    a_hold_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !q_pop |=> ($stable(count_reg) && $stable(window_reg)))
        else $error("state moved without a pop");
`endif

endmodule

`default_nettype wire

/* src/cpfv_judge.sv */
`default_nettype none

module cpfv_judge (
    input  wire logic            aclk,
    input  wire logic            aresetn,
    input  wire logic            job_valid,
    output logic                 job_ready,
    input  cpfv_pkg::job_t       job,
    output logic                 m_valid,
    input  wire logic            m_ready,
    output logic                 m_valid_res,
    output logic [2:0]           m_status
);
    import cpfv_pkg::*;

    logic adv;

    // stage 1: captured job
    logic               s1_valid_reg;
    job_t               s1_reg;

    // stage 2: weighted sums and flags
    logic               s2_valid_reg;
    logic               s2_empty_reg, s2_many_reg, s2_equal_reg;
    logic [SUM_W-1:0]   s2_sum1_reg, s2_sum2_reg;
    logic [DIGIT_W-1:0] s2_d9_reg, s2_d10_reg;

    // stage 3: raw remainders, below twice the modulus
    logic               s3_valid_reg;
    logic               s3_empty_reg, s3_many_reg, s3_equal_reg;
    logic [4:0]         s3_r1_reg, s3_r2_reg;
    logic [DIGIT_W-1:0] s3_d9_reg, s3_d10_reg;

    logic               out_valid_reg;
    status_t            out_status_reg, status_next;

    logic [SUM_W-1:0]   sum1, sum2;
    logic               equal;
    logic [4:0]         r1, r2;
    logic [DIGIT_W-1:0] chk1, chk2;

    assign adv       = !out_valid_reg || m_ready;
    assign job_ready = adv;

    function automatic logic [4:0] mod11_raw(input logic [SUM_W-1:0] s);
        logic [SUM_W+8:0] prod;
        logic [SUM_W-1:0] q;
        logic [SUM_W-1:0] rem;
        prod = s * RECIP_11;
        q    = SUM_W'(prod >> RECIP_SHIFT);
        rem  = s - SUM_W'(q * MODULUS);
        return rem[4:0];
    endfunction

    function automatic logic [DIGIT_W-1:0] check_of(input logic [4:0] raw);
        logic [4:0] r;
        logic [4:0] c;
        r = (raw >= 5'(MODULUS)) ? raw - 5'(MODULUS) : raw;
        // 10 * r mod 11 is 11 - r; a result of ten maps to zero
        c = (r <= 5'd1) ? 5'd0 : 5'(MODULUS) - r;
        return c[DIGIT_W-1:0];
    endfunction

    always_comb begin
        sum1  = '0;
        sum2  = '0;
        equal = 1'b1;
        for (int i = 0; i < DIGIT_COUNT; i++) begin
            sum1 = sum1 + SUM_W'(s1_reg.window[i]) * SUM_W'(WEIGHT_FIRST[i]);
            sum2 = sum2 + SUM_W'(s1_reg.window[i]) * SUM_W'(WEIGHT_SECOND[i]);
            if (s1_reg.window[i] != s1_reg.window[0]) begin
                equal = 1'b0;
            end
        end
    end

    assign r1 = mod11_raw(s2_sum1_reg);
    assign r2 = mod11_raw(s2_sum2_reg);

    assign chk1 = check_of(s3_r1_reg);
    assign chk2 = check_of(s3_r2_reg);

    always_comb begin
        if (s3_empty_reg) begin
            status_next = ST_EMPTY;
        end else if (s3_many_reg) begin
            status_next = ST_LENGTH;
        end else if (s3_equal_reg) begin
            status_next = ST_EQUAL;
        end else if (chk1 != s3_d9_reg) begin
            status_next = ST_FIRST;
        end else if (chk2 != s3_d10_reg) begin
            status_next = ST_SECOND;
        end else begin
            status_next = ST_OK;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg  <= 1'b0;
            s2_valid_reg  <= 1'b0;
            s3_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            s1_valid_reg  <= job_valid;
            s2_valid_reg  <= s1_valid_reg;
            s3_valid_reg  <= s2_valid_reg;
            out_valid_reg <= s3_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            s1_reg         <= job;
            s2_empty_reg   <= s1_reg.empty;
            s2_many_reg    <= s1_reg.too_many;
            s2_equal_reg   <= equal;
            s2_sum1_reg    <= sum1;
            s2_sum2_reg    <= sum2;
            s2_d9_reg      <= s1_reg.window[DIGIT_COUNT-2];
            s2_d10_reg     <= s1_reg.window[DIGIT_COUNT-1];
            s3_empty_reg   <= s2_empty_reg;
            s3_many_reg    <= s2_many_reg;
            s3_equal_reg   <= s2_equal_reg;
            s3_r1_reg      <= r1;
            s3_r2_reg      <= r2;
            s3_d9_reg      <= s2_d9_reg;
            s3_d10_reg     <= s2_d10_reg;
            out_status_reg <= status_next;
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_status    = out_status_reg;
    assign m_valid_res = (out_status_reg == ST_OK);

`ifndef SYNTH
    a_ok_flag: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_valid_res) |-> (m_status == ST_OK))
        else $error("valid flag with failing status");
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(s3_valid_reg))
        else $error("result without a job in the last stage");
    a_remainder_range: assert property (@(posedge aclk) disable iff (!aresetn)
        s3_valid_reg |-> (s3_r1_reg < 5'd22 && s3_r2_reg < 5'd22))
        else $error("remainder estimate out of range");
`endif

endmodule

`default_nettype wire

/* src/cpf_check_digit_validator_top.sv */
// Channel   Ports                                            Direction
// s_        s_valid s_ready s_char_byte s_last_char          in, one character a beat
//           s_empty_string
// m_        m_valid m_ready m_valid_res m_status             out, one result per string
//
// One character a cycle while the queue is not full (s_ready high).
// A string's last beat passes the queue, then judge capture, sums, remainder estimate, status.
// Reset (aresetn low, synchronous) empties the queue and clears window and count.
// A stall on m_ stops the judge pipe; the 4-entry queue absorbs characters until full.
`default_nettype none

module cpf_check_digit_validator_top #(
    parameter int QUEUE_DEPTH = cpfv_pkg::QUEUE_DEPTH
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [7:0]  s_char_byte,
    input  wire logic        s_last_char,
    input  wire logic        s_empty_string,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic             m_valid_res,
    output logic [2:0]       m_status
);
    import cpfv_pkg::*;

    logic    q_push, q_full, q_pop, q_nonempty;
    token_t  push_token, pop_token;
    logic    job_valid, job_ready;
    job_t    job;

    cpfv_front u_front (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_last_char    (s_last_char),
        .s_empty_string (s_empty_string),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_token        (push_token)
    );

    cpfv_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (q_push),
        .push_data (push_token),
        .full      (q_full),
        .pop       (q_pop),
        .pop_data  (pop_token),
        .nonempty  (q_nonempty)
    );

    cpfv_track u_track (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_token    (pop_token),
        .q_nonempty (q_nonempty),
        .q_pop      (q_pop),
        .job_valid  (job_valid),
        .job_ready  (job_ready),
        .job        (job)
    );

    cpfv_judge u_judge (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .job_valid   (job_valid),
        .job_ready   (job_ready),
        .job         (job),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_valid_res (m_valid_res),
        .m_status    (m_status)
    );

endmodule

`default_nettype wire

/* tb/sv/cpf_check_digit_validator_checker.sv */
`timescale 1ns / 1ps

module cpf_check_digit_validator_checker (
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       s_valid,
    input  wire logic       s_ready,
    input  wire logic [7:0] s_char_byte,
    input  wire logic       s_last_char,
    input  wire logic       s_empty_string,
    input  wire logic       m_valid,
    input  wire logic       m_ready,
    input  wire logic       m_valid_res,
    input  wire logic [2:0] m_status,
    output int              fail_count,
    output int              pending
);
    import cpfv_pkg::*;

    localparam int         NUM_DIGITS = 11;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam int         FIRST_WEIGHTS  [NUM_DIGITS] = '{10, 9, 8, 7, 6, 5, 4, 3, 2, 0, 0};
    localparam int         SECOND_WEIGHTS [NUM_DIGITS] = '{11, 10, 9, 8, 7, 6, 5, 4, 3, 2, 0};

    typedef struct packed {
        logic    valid_res;
        status_t status;
    } verdict_t;

    logic [3:0] win [NUM_DIGITS];
    logic [3:0] digits_seen;
    verdict_t   verdict_q [$];
    verdict_t   want;
    int         errors_seen = 0;

    function automatic int mod_check(input int total);
        int r;
        r = (total * 10) % 11;
        return (r == 10) ? 0 : r;
    endfunction

    function automatic status_t judge_window();
        int   sum_a;
        int   sum_b;
        int   i;
        logic same;
        sum_a = 0;
        sum_b = 0;
        same  = 1'b1;
        if (digits_seen > NUM_DIGITS) return ST_LENGTH;
        for (i = 1; i < NUM_DIGITS; i++) begin
            if (win[i] != win[0]) same = 1'b0;
        end
        if (same) return ST_EQUAL;
        for (i = 0; i < NUM_DIGITS; i++) begin
            sum_a += win[i] * FIRST_WEIGHTS[i];
            sum_b += win[i] * SECOND_WEIGHTS[i];
        end
        if (mod_check(sum_a) != win[NUM_DIGITS-2]) return ST_FIRST;
        if (mod_check(sum_b) != win[NUM_DIGITS-1]) return ST_SECOND;
        return ST_OK;
    endfunction

    task automatic clear_window();
        int i;
        for (i = 0; i < NUM_DIGITS; i++) win[i] = 4'd0;
        digits_seen = 4'd0;
    endtask

    task automatic queue_verdict(input verdict_t v);
        verdict_q = {verdict_q, v};
    endtask

    task automatic absorb_char(input logic [7:0] ch, input logic last, input logic empty);
        verdict_t v;
        int       i;
        if (empty) begin
            if (last) begin
                clear_window();
                v.valid_res = 1'b0;
                v.status    = ST_EMPTY;
                queue_verdict(v);
            end
        end else begin
            if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
                for (i = 0; i < NUM_DIGITS - 1; i++) win[i] = win[i+1];
                win[NUM_DIGITS-1] = 4'(ch - CHAR_ZERO);
                if (digits_seen <= NUM_DIGITS) digits_seen = digits_seen + 4'd1;
            end
            if (last) begin
                v.status    = judge_window();
                v.valid_res = (v.status == ST_OK);
                queue_verdict(v);
                clear_window();
            end
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            clear_window();
            verdict_q.delete();
            pending <= 0;
        end else begin
            if (m_valid && m_ready) begin
                if (verdict_q.size() == 0) begin
                    if (errors_seen < 10)
                        $display("result with nothing pending: valid_res=%0b status=%0d",
                                 m_valid_res, m_status);
                    errors_seen++;
                end else begin
                    want = verdict_q.pop_front();
                    if (m_valid_res !== want.valid_res || m_status !== want.status) begin
                        if (errors_seen < 10)
                            $display("mismatch: expected valid_res=%0b status=%0d, got %0b %0d",
                                     want.valid_res, want.status, m_valid_res, m_status);
                        errors_seen++;
                    end
                end
            end
            if (s_valid && s_ready) absorb_char(s_char_byte, s_last_char, s_empty_string);
            pending    <= verdict_q.size();
            fail_count <= errors_seen;
        end
    end

endmodule

/* tb/sv/cpf_check_digit_validator_top_tb.sv */
`timescale 1ns / 1ps

module cpf_check_digit_validator_top_tb;

    logic       aclk           = 1'b0;
    logic       aresetn        = 1'b0;
    logic       s_valid        = 1'b0;
    logic       s_ready;
    logic [7:0] s_char_byte    = 8'h00;
    logic       s_last_char    = 1'b0;
    logic       s_empty_string = 1'b0;
    logic       m_valid;
    logic       m_ready        = 1'b0;
    logic       m_valid_res;
    logic [2:0] m_status;

    int         fail_count;
    int         pending;
    bit         idle_on    = 1'b0;
    bit         drained    = 1'b0;
    int         stall_left = 0;
    int         stall_next;
    int         sent_items = 0;
    logic [7:0] text_q [$];

    cpf_check_digit_validator_top u_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_last_char    (s_last_char),
        .s_empty_string (s_empty_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_status       (m_status)
    );

    cpf_check_digit_validator_checker u_checker (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_char_byte    (s_char_byte),
        .s_last_char    (s_last_char),
        .s_empty_string (s_empty_string),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_valid_res    (m_valid_res),
        .m_status       (m_status),
        .fail_count     (fail_count),
        .pending        (pending)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        if (stall_left > 0)
            stall_next = stall_left - 1;
        else if (idle_on && $urandom_range(0, 5) == 0)
            stall_next = $urandom_range(1, 9);
        else
            stall_next = 0;
        stall_left <= stall_next;
        m_ready    <= (stall_next == 0);
    end

    function automatic int check_of(input int total);
        int r;
        r = (total * 10) % 11;
        return (r == 10) ? 0 : r;
    endfunction

    task automatic send_beat(input logic [7:0] ch, input logic last, input logic empty);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            s_valid <= 1'b0;
            repeat ($urandom_range(1, 9)) @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_char_byte    <= ch;
        s_last_char    <= last;
        s_empty_string <= empty;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sent_items++;
    endtask

    task automatic add_char(input logic [7:0] ch);
        text_q = {text_q, ch};
    endtask

    task automatic send_text(input bit end_empty);
        int i;
        int n;
        n = text_q.size();
        for (i = 0; i < n; i++) begin
            if ($urandom_range(0, 19) == 0) send_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1);
            send_beat(text_q[i], (i == n - 1) && !end_empty, 1'b0);
        end
        if (end_empty || n == 0) send_beat(8'($urandom_range(0, 255)), 1'b1, 1'b1);
        text_q.delete();
    endtask

    task automatic wait_results();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic make_cpf();
        int d [11];
        int sum;
        int i;
        int lead;
        int start;
        int pos;
        bit fancy;
        lead = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 8) : 0;
        for (i = 0; i < 9; i++) d[i] = (i < lead) ? 0 : $urandom_range(0, 9);
        sum = 0;
        for (i = 0; i < 9; i++) sum += d[i] * (10 - i);
        d[9] = check_of(sum);
        sum = 0;
        for (i = 0; i < 10; i++) sum += d[i] * (11 - i);
        d[10] = check_of(sum);
        if ($urandom_range(0, 3) == 0) begin
            pos    = ($urandom_range(0, 1) == 0) ? $urandom_range(9, 10) : $urandom_range(0, 8);
            d[pos] = (d[pos] + $urandom_range(1, 9)) % 10;
        end
        fancy = ($urandom_range(0, 1) == 1);
        start = ($urandom_range(0, 1) == 0) ? lead : 0;
        for (i = start; i < 11; i++) begin
            if (fancy && (i == 3 || i == 6)) add_char(8'h2E);
            if (fancy && i == 9) add_char(8'h2D);
            add_char(8'(8'h30 + d[i]));
        end
        if ($urandom_range(0, 5) == 0) text_q.push_front(8'h20);
        if ($urandom_range(0, 7) == 0) add_char(8'($urandom_range(128, 255)));
    endtask

    task automatic make_string();
        int k;
        int n;
        int i;
        int v;
        k = $urandom_range(0, 19);
        case (k)
            12, 13: begin
                v = $urandom_range(0, 9);
                for (i = 0; i < 11; i++) begin
                    if (i == 9 && $urandom_range(0, 1) == 0) add_char(8'h2D);
                    add_char(8'(8'h30 + v));
                end
                send_text(1'b0);
            end
            14, 15: begin
                n = $urandom_range(12, 16);
                for (i = 0; i < n; i++) add_char(8'(8'h30 + $urandom_range(0, 9)));
                send_text(1'b0);
            end
            16: begin
                n = $urandom_range(0, 10);
                for (i = 0; i < n; i++) begin
                    if ($urandom_range(0, 2) == 0)
                        add_char(8'($urandom_range(0, 255)));
                    else
                        add_char(8'(8'h30 + $urandom_range(0, 9)));
                end
                send_text(1'b0);
            end
            17: begin
                n = $urandom_range(1, 6);
                for (i = 0; i < n; i++) add_char(8'($urandom_range(0, 255)));
                send_text(1'b0);
            end
            18: begin
                n = $urandom_range(1, 11);
                for (i = 0; i < n; i++) add_char(8'(8'h30 + $urandom_range(0, 9)));
                send_text(1'b1);
            end
            19: send_text(1'b1);
            default: begin
                make_cpf();
                send_text(1'b0);
            end
        endcase
    endtask

    initial begin
        int i;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        idle_on = 1'b1;

        send_beat(8'hFF, 1'b1, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b0);
        send_beat(8'hFF, 1'b1, 1'b0);
        send_beat(8'h2F, 1'b0, 1'b0);
        send_beat(8'h3A, 1'b1, 1'b0);
        send_beat(8'h35, 1'b0, 1'b0);
        send_beat(8'h37, 1'b0, 1'b0);
        send_beat(8'h00, 1'b1, 1'b1);
        send_beat(8'h31, 1'b0, 1'b0);
        send_beat(8'h39, 1'b0, 1'b0);
        send_beat(8'h31, 1'b1, 1'b0);
        send_beat(8'h39, 1'b1, 1'b0);
        for (i = 0; i < 12; i++) send_beat(8'(8'h30 + (i % 10)), i == 11, 1'b0);

        while (sent_items < 445) begin
            idle_on = (sent_items < 170) || (sent_items >= 240 && sent_items < 400);
            if (!drained && sent_items >= 300) begin
                wait_results();
                drained = 1'b1;
            end
            make_string();
        end

        wait_results();
        repeat (20) @(posedge aclk);
        if (fail_count == 0 && pending == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("TB_ERROR");
        $finish;
    end

endmodule

/* files.f */
src/cpfv_pkg.sv
src/cpfv_front.sv
src/cpfv_queue.sv
src/cpfv_track.sv
src/cpfv_judge.sv
src/cpf_check_digit_validator_top.sv
tb/sv/cpf_check_digit_validator_checker.sv
tb/sv/cpf_check_digit_validator_top_tb.sv
